// ===== rtl/lens_transfer_matrix_accumulator_core_defines.svh =====
// ---------------------------------------------------------------------------
// Lens transfer matrix accumulator - assertion macros
// Shared concurrent assertion forms; clocked on clk, disabled while rst_n low.
// ---------------------------------------------------------------------------
`ifndef LENS_TRANSFER_MATRIX_ACCUMULATOR_CORE_DEFINES_SVH
`define LENS_TRANSFER_MATRIX_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication
`define LTMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LTMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ltma_pkg.sv =====
// ---------------------------------------------------------------------------
// ltma_pkg
// Types and constants shared by the lens transfer matrix accumulator.
// ---------------------------------------------------------------------------
package ltma_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IOR_W      = 19;
  localparam int RAD_W      = 32;
  localparam int THK_W      = 25;
  localparam int Q_W        = 32;
  localparam int AP_W       = 6;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // Divider widths: numerator magnitude, shifted dividend, divisor magnitude
  localparam int NUM_W      = IOR_W;
  localparam int DVD_W      = NUM_W + FRAC_BITS;
  localparam int DEN_W      = 34;
  localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

  // Product and scaled-product widths
  localparam int PROD_W     = 2 * Q_W;
  localparam int FS_W       = PROD_W - FRAC_BITS;
  localparam int SUM_W      = FS_W + 1;

  // Radius magnitudes at or below this are treated as flat (|r| <= 1e-4)
  localparam logic [RAD_W-1:0] FLAT_LIMIT = RAD_W'((1 << FRAC_BITS) / 10000);

  localparam logic signed [Q_W-1:0] QONE   = Q_W'(1 << FRAC_BITS);
  localparam logic signed [Q_W-1:0] S32MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] S32MIN = 32'sh8000_0000;

  // Register addresses
  localparam logic [APB_AW-1:0] ADDR_APERTURE = 3'd0;

  // Matrix entry positions
  localparam int MA = 0;
  localparam int MB = 1;
  localparam int MC = 2;
  localparam int MD = 3;

  // Multiply sequence steps
  localparam logic [2:0] ST_PC_LO = 3'd0;
  localparam logic [2:0] ST_PC_HI = 3'd1;
  localparam logic [2:0] ST_PD_LO = 3'd2;
  localparam logic [2:0] ST_PD_HI = 3'd3;
  localparam logic [2:0] ST_NA    = 3'd4;
  localparam logic [2:0] ST_NB    = 3'd5;

  typedef struct packed {
    logic [IOR_W-1:0] n1;
    logic [IOR_W-1:0] n2;
    logic             rneg;
    logic [RAD_W-1:0] rmag;
    logic [THK_W-1:0] thick;
    logic             flat;
    logic             to_front;
    logic             last;
  } ltma_entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num_mag;
    logic             num_neg;
    logic             den_neg;
    logic [DEN_W-1:0] den_mag;
  } ltma_div_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [Q_W-1:0] quot;
    logic                  clip;
  } ltma_div_rsp_t;

  typedef struct packed {
    logic                  clip;
    logic signed [Q_W-1:0] val;
  } ltma_sat_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_D_GO, BK_D_WAIT, BK_DEN, BK_C_GO, BK_C_WAIT, BK_MUL, BK_ACC, BK_OUT
  } bk_state_t;

  // Product scaled down by FRAC_BITS, rounding toward minus infinity
  function automatic logic signed [FS_W-1:0] floor_scale(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> FRAC_BITS;
    return s[FS_W-1:0];
  endfunction

  // Clip a sum to 32 bits
  function automatic ltma_sat_t sat32(input logic signed [SUM_W-1:0] v);
    ltma_sat_t r;
    if ((&v[SUM_W-1:Q_W-1]) || !(|v[SUM_W-1:Q_W-1])) begin
      r.clip = 1'b0;
      r.val  = v[Q_W-1:0];
    end else begin
      r.clip = 1'b1;
      r.val  = v[SUM_W-1] ? S32MIN : S32MAX;
    end
    return r;
  endfunction

endpackage

// ===== rtl/ltma_if.sv =====
// ---------------------------------------------------------------------------
// ltma_in_if / ltma_out_if
// Valid/ready channels for lens elements and for emitted matrix pairs.
// ---------------------------------------------------------------------------
interface ltma_in_if;
  logic                valid;
  logic                ready;
  logic [18:0]         prev_ior;
  logic [18:0]         cur_ior;
  logic signed [31:0]  surface_radius;
  logic [24:0]         element_thickness;
  logic                is_stop;
  logic                last;

  modport source (output valid, prev_ior, cur_ior, surface_radius, element_thickness,
                  is_stop, last, input ready);
  modport sink   (input valid, prev_ior, cur_ior, surface_radius, element_thickness,
                  is_stop, last, output ready);
endinterface

interface ltma_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  front_a;
  logic signed [31:0]  front_b;
  logic signed [31:0]  front_c;
  logic signed [31:0]  front_d;
  logic signed [31:0]  rear_a;
  logic signed [31:0]  rear_b;
  logic signed [31:0]  rear_c;
  logic signed [31:0]  rear_d;
  logic                saturated;

  modport source (output valid, front_a, front_b, front_c, front_d, rear_a, rear_b,
                  rear_c, rear_d, saturated, input ready);
  modport sink   (input valid, front_a, front_b, front_c, front_d, rear_a, rear_b,
                  rear_c, rear_d, saturated, output ready);
endinterface

// ===== rtl/ltma_front.sv =====
// ---------------------------------------------------------------------------
// ltma_front
// Accepts lens elements, holds the aperture register, numbers the elements
// and classifies each one (flat surface, front or rear matrix).
// ---------------------------------------------------------------------------
module ltma_front import ltma_pkg::*; #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  ltma_in_if.sink            in_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  input  logic               q_full,
  output logic               q_push,
  output ltma_entry_t        q_data
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W = (CNT_W + 1 > AP_W) ? CNT_W + 1 : AP_W;

  logic [AP_W-1:0]  ap_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CMP_W-1:0] pos;
  logic [RAD_W-1:0] rmag;
  logic             ap_sel;

  // Register port; word decode ignores the byte offset
  assign ap_sel = (paddr[APB_AW-1:2] == ADDR_APERTURE[APB_AW-1:2]);
  assign pready = 1'b1;
  assign prdata = ap_sel ? APB_DW'(ap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_r <= '0;
    end else if (psel && penable && pwrite && ap_sel) begin
      ap_r <= pwdata[AP_W-1:0];
    end
  end

  // Handshake into the queue
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Classification
  assign rmag = in_ch.surface_radius[RAD_W-1] ? RAD_W'(-in_ch.surface_radius)
                                              : RAD_W'(in_ch.surface_radius);
  assign pos  = CMP_W'(cnt_r) + CMP_W'(1);

  always_comb begin
    q_data.n1       = in_ch.prev_ior;
    q_data.n2       = in_ch.cur_ior;
    q_data.rneg     = in_ch.surface_radius[RAD_W-1];
    q_data.rmag     = rmag;
    q_data.thick    = in_ch.element_thickness;
    q_data.flat     = in_ch.is_stop || (rmag <= FLAT_LIMIT);
    q_data.to_front = (ap_r != '0) && (pos < CMP_W'(ap_r));
    q_data.last     = in_ch.last;
  end

  // Element counter, saturating, cleared by the last element
  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_ch.last) begin
        cnt_nxt = '0;
      end else if (cnt_r < CNT_W'(MAX_ELEMENTS)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/ltma_queue.sv =====
// ---------------------------------------------------------------------------
// ltma_queue
// Two-entry queue of classified elements between front and back.
// ---------------------------------------------------------------------------
module ltma_queue import ltma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ltma_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output ltma_entry_t head
);

`include "lens_transfer_matrix_accumulator_core_defines.svh"

  ltma_entry_t mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  `LTMA_ASSERT_IMP(a_q_cnt_range, 1'b1, cnt_r != 2'd3, "queue count out of range")
  `LTMA_ASSERT_IMP(a_q_no_underflow, pop, cnt_r != 2'd0, "pop from empty queue")
  `LTMA_ASSERT_NXT(a_q_fill, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "queue count lost")

endmodule

// ===== rtl/ltma_div.sv =====
// ---------------------------------------------------------------------------
// ltma_div
// Radix-2 restoring divider for (num << FRAC_BITS) / den, truncating toward
// zero, with 32-bit saturation and a zero-divisor result.
// ---------------------------------------------------------------------------
module ltma_div import ltma_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  ltma_div_req_t req,
  output ltma_div_rsp_t rsp
);

  localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(64'h7fff_ffff);
  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(64'h8000_0000);

  logic                 busy_r, fin_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]     dvd_r, quo_r;
  logic [DEN_W-1:0]     rem_r, den_r;
  logic                 neg_r, nneg_r;
  ltma_div_rsp_t        rsp_r;
  logic [DEN_W:0]       trial, diff;
  logic                 ge;
  logic [Q_W-1:0]       qlo;

  assign rsp = rsp_r;

  // One quotient bit per cycle while busy
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});
  assign qlo   = quo_r[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
    end else if (req.start) begin
      rem_r  <= '0;
      quo_r  <= '0;
      dvd_r  <= {req.num_mag, {FRAC_BITS{1'b0}}};
      den_r  <= req.den_mag;
      neg_r  <= req.num_neg ^ req.den_neg;
      nneg_r <= req.num_neg;
    end
  end

  // Sequencing and saturated result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      fin_r      <= 1'b0;
      cnt_r      <= '0;
      rsp_r.done <= 1'b0;
      rsp_r.quot <= '0;
      rsp_r.clip <= 1'b0;
    end else begin
      rsp_r.done <= 1'b0;
      fin_r      <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        rsp_r.done <= 1'b1;
        if (neg_r) begin
          rsp_r.clip <= (quo_r > NEG_LIM);
          rsp_r.quot <= (quo_r > NEG_LIM) ? S32MIN : -$signed(qlo);
        end else begin
          rsp_r.clip <= (quo_r > POS_LIM);
          rsp_r.quot <= (quo_r > POS_LIM) ? S32MAX : $signed(qlo);
        end
      end else if (req.start) begin
        if (req.den_mag == '0) begin
          rsp_r.done <= 1'b1;
          rsp_r.clip <= 1'b1;
          rsp_r.quot <= req.num_neg ? S32MIN : S32MAX;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= DIV_CNT_W'(DVD_W);
        end
      end
    end
  end

  `LTMA_ASSERT_IMP(a_div_excl, busy_r, !fin_r, "divider busy and finishing together")
  `LTMA_ASSERT_NXT(a_div_fin, busy_r && cnt_r == DIV_CNT_W'(1), fin_r, "divider missed finish")
  `LTMA_ASSERT_NXT(a_div_done, fin_r, rsp_r.done, "divider result not posted")

endmodule

// ===== rtl/ltma_back.sv =====
// ---------------------------------------------------------------------------
// ltma_back
// Builds the refraction and translation terms of one element and applies
// them to the front or rear matrix with one shared multiplier; emits both
// matrices on the last element.
// ---------------------------------------------------------------------------
module ltma_back import ltma_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  ltma_entry_t   q_head,
  output logic          q_pop,
  output ltma_div_req_t div_req,
  input  ltma_div_rsp_t div_rsp,
  ltma_out_if.source    out_ch
);

`include "lens_transfer_matrix_accumulator_core_defines.svh"

  bk_state_t state_r, state_nxt;

  ltma_entry_t               ent_r;
  logic [2:0]                step_r;
  logic signed [Q_W-1:0]     fm_r [4];
  logic signed [Q_W-1:0]     rm_r [4];
  logic signed [Q_W-1:0]     cm [4];
  logic                      clip_r;
  logic signed [Q_W-1:0]     c_r, d_r, pc_r, pd_r, na_r;
  logic [DEN_W-1:0]          den_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [FS_W-1:0]    acc_r, fs;
  logic signed [Q_W-1:0]     opa, opb, thk;
  logic signed [SUM_W-1:0]   sum;
  ltma_sat_t                 sr;
  logic [IOR_W+RAD_W-1:0]    dprod;
  logic signed [IOR_W:0]     ndiff;
  logic                      div_start, load_out, acc_last;
  logic                      out_valid_r;
  logic signed [Q_W-1:0]     res_f [4];
  logic signed [Q_W-1:0]     res_r [4];
  logic signed [Q_W-1:0]     rres_r [4];
  logic                      res_sat_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:   if (!q_empty) state_nxt = BK_D_GO;
      BK_D_GO:   state_nxt = BK_D_WAIT;
      BK_D_WAIT: if (div_rsp.done) state_nxt = ent_r.flat ? BK_MUL : BK_DEN;
      BK_DEN:    state_nxt = BK_C_GO;
      BK_C_GO:   state_nxt = BK_C_WAIT;
      BK_C_WAIT: if (div_rsp.done) state_nxt = BK_MUL;
      BK_MUL:    state_nxt = BK_ACC;
      BK_ACC:    if (step_r == ST_NB) state_nxt = ent_r.last ? BK_OUT : BK_IDLE;
                 else state_nxt = BK_MUL;
      BK_OUT:    if (!out_valid_r || out_ch.ready) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop     = (state_r == BK_IDLE) && !q_empty;
    div_start = (state_r == BK_D_GO) || (state_r == BK_C_GO);
    load_out  = (state_r == BK_OUT) && (!out_valid_r || out_ch.ready);
    acc_last  = (state_r == BK_ACC) && (step_r == ST_NB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Divider operands: n1/n2 first, then (n1-n2)/(n2*r)
  assign ndiff = $signed({1'b0, ent_r.n1}) - $signed({1'b0, ent_r.n2});

  always_comb begin
    div_req.start = div_start;
    if (state_r == BK_C_GO) begin
      div_req.num_neg = ndiff[IOR_W];
      div_req.num_mag = ndiff[IOR_W] ? NUM_W'(-ndiff) : NUM_W'(ndiff);
      div_req.den_neg = ent_r.rneg;
      div_req.den_mag = den_r;
    end else begin
      div_req.num_neg = 1'b0;
      div_req.num_mag = ent_r.n1;
      div_req.den_neg = 1'b0;
      div_req.den_mag = DEN_W'(ent_r.n2);
    end
  end

  assign dprod = (IOR_W+RAD_W)'(ent_r.n2) * (IOR_W+RAD_W)'(ent_r.rmag);

  // Operand selection for the shared multiplier
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cm[k] = ent_r.to_front ? fm_r[k] : rm_r[k];
    end
  end

  assign thk = $signed(Q_W'(ent_r.thick));

  always_comb begin
    unique case (step_r)
      ST_PC_LO: begin opa = c_r; opb = cm[MA];  end
      ST_PC_HI: begin opa = d_r; opb = cm[MC];  end
      ST_PD_LO: begin opa = c_r; opb = cm[MB];  end
      ST_PD_HI: begin opa = d_r; opb = cm[MD];  end
      ST_NA:    begin opa = thk; opb = pc_r;    end
      default:  begin opa = thk; opb = pd_r;    end
    endcase
  end

  // Accumulate and clip
  assign fs = floor_scale(prod_r);

  always_comb begin
    if (step_r == ST_NA) begin
      sum = SUM_W'(cm[MA]) + SUM_W'(fs);
    end else if (step_r == ST_NB) begin
      sum = SUM_W'(cm[MB]) + SUM_W'(fs);
    end else begin
      sum = SUM_W'(acc_r) + SUM_W'(fs);
    end
    sr = sat32(sum);
  end

  // Result snapshot
  always_comb begin
    res_f[0] = fm_r[MA];
    res_f[1] = fm_r[MB];
    res_f[2] = fm_r[MC];
    res_f[3] = fm_r[MD];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_head;
    end
    if (state_r == BK_IDLE) begin
      step_r <= ST_PC_LO;
    end else if (state_r == BK_ACC) begin
      step_r <= step_r + 3'd1;
    end
    if (state_r == BK_D_WAIT && div_rsp.done) begin
      d_r <= div_rsp.quot;
      c_r <= '0;
    end
    if (state_r == BK_C_WAIT && div_rsp.done) begin
      c_r <= div_rsp.quot;
    end
    if (state_r == BK_DEN) begin
      den_r <= dprod[DEN_W+FRAC_BITS-1:FRAC_BITS];
    end
    if (state_r == BK_MUL) begin
      prod_r <= opa * opb;
    end
    if (state_r == BK_ACC) begin
      unique case (step_r)
        ST_PC_LO, ST_PD_LO: acc_r <= fs;
        ST_PC_HI: pc_r <= sr.val;
        ST_PD_HI: pd_r <= sr.val;
        ST_NA:    na_r <= sr.val;
        default:  ;
      endcase
    end
    if (load_out) begin
      for (int k = 0; k < 4; k++) begin
        res_r[k] <= res_f[k];
      end
      res_sat_r <= clip_r;
    end
  end

  // Running matrices and clip flag
  always_ff @(posedge clk) begin
    if (!rst_n || load_out) begin
      fm_r[MA] <= QONE; fm_r[MB] <= '0; fm_r[MC] <= '0; fm_r[MD] <= QONE;
      rm_r[MA] <= QONE; rm_r[MB] <= '0; rm_r[MC] <= '0; rm_r[MD] <= QONE;
      clip_r   <= 1'b0;
    end else begin
      if (div_rsp.done && div_rsp.clip) begin
        clip_r <= 1'b1;
      end
      if (state_r == BK_ACC && step_r != ST_PC_LO && step_r != ST_PD_LO && sr.clip) begin
        clip_r <= 1'b1;
      end
      if (acc_last) begin
        if (ent_r.to_front) begin
          fm_r[MA] <= na_r; fm_r[MB] <= sr.val; fm_r[MC] <= pc_r; fm_r[MD] <= pd_r;
        end else begin
          rm_r[MA] <= na_r; rm_r[MB] <= sr.val; rm_r[MC] <= pc_r; rm_r[MD] <= pd_r;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Rear half of the result lives in its own register bank
  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int k = 0; k < 4; k++) begin
        rres_r[k] <= rm_r[k];
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.front_a   = res_r[0];
  assign out_ch.front_b   = res_r[1];
  assign out_ch.front_c   = res_r[2];
  assign out_ch.front_d   = res_r[3];
  assign out_ch.rear_a    = rres_r[0];
  assign out_ch.rear_b    = rres_r[1];
  assign out_ch.rear_c    = rres_r[2];
  assign out_ch.rear_d    = rres_r[3];
  assign out_ch.saturated = res_sat_r;

  `LTMA_ASSERT_IMP(a_bk_pop_idle, q_pop, state_r == BK_IDLE, "queue popped while busy")
  `LTMA_ASSERT_IMP(a_bk_out_src, out_valid_r && !$past(out_valid_r),
                   $past(state_r) == BK_OUT, "result appeared outside emit")
  `LTMA_ASSERT_IMP(a_bk_div_wait, div_rsp.done,
                   state_r == BK_D_WAIT || state_r == BK_C_WAIT, "unexpected quotient")

endmodule

// ===== rtl/lens_transfer_matrix_accumulator_core.sv =====
// ---------------------------------------------------------------------------
// lens_transfer_matrix_accumulator_core
// Paraxial ABCD matrix accumulator: lens elements in, front and rear
// transfer matrices out on the last element of each system.
// ---------------------------------------------------------------------------
//  channel   | role   | handshake            | carries
//  in_ch     | sink   | valid/ready          | one lens element
//  out_ch    | source | valid/ready          | front and rear matrices, clip flag
//  APB       | slave  | psel/penable/pwrite  | aperture_position at 0x0
//
// A flat surface needs one quotient from the shared radix-2 divider and a
// curved one needs two; the single multiplier then forms the matrix
// products one step at a time.
// A two-entry queue lets the input side keep taking elements while the back
// end works or a result waits. Reset is synchronous; no clearing pass.
// ---------------------------------------------------------------------------
module lens_transfer_matrix_accumulator_core import ltma_pkg::*; #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  ltma_in_if.sink            in_ch,
  ltma_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic          q_full, q_empty, q_push, q_pop;
  ltma_entry_t   q_in, q_head;
  ltma_div_req_t div_req;
  ltma_div_rsp_t div_rsp;

  // Front end: intake and classification
  ltma_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
    .clk, .rst_n, .in_ch,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .q_full, .q_push, .q_data(q_in)
  );

  // Decoupling queue
  ltma_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  // Shared divider
  ltma_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  // Back end: matrix update and emission
  ltma_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop, .div_req, .div_rsp, .out_ch
  );

endmodule
